// ===== hw/rtl/cpr_pkg.sv =====
// Shared types, constants and a helper function for the clock plate relay stepper.
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  localparam int unsigned POSITIONS            = 64;
  localparam int unsigned POS_W                = 6;
  localparam logic [POS_W-1:0] NIGHT_POS       = POS_W'(POSITIONS - 1);
  localparam int unsigned MINUTES_PER_POSITION = 15;
  localparam int unsigned TICKS_PER_PHASE      = 6;
  localparam int unsigned TICK_W               = 3;
  localparam logic [TICK_W-1:0] TICK_SAT       = 3'd7;
  localparam int unsigned STEP_BOUNDARY        = 6;
  localparam int unsigned MIN_W                = 11;
  localparam logic [MIN_W-1:0] MIN_PER_HOUR    = 11'd60;

  typedef enum logic [1:0] {
    CFG_START_MINUTE     = 2'd0,
    CFG_END_MINUTE       = 2'd1,
    CFG_PLATE_CONFIGURED = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_STABLE = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef struct packed {
    logic             func;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
    logic             time_valid;
    logic             sqw_active;
    logic             manual_hold;
    logic             persist_ok;
    logic [POS_W-1:0] new_position;
  } item_t;

  typedef struct packed {
    logic [MIN_W-1:0] start_minute;
    logic [MIN_W-1:0] end_minute;
    logic             plate_configured;
  } cfg_t;

  typedef struct packed {
    logic ld_diff;
    logic ld_tgt;
    logic ld_out;
  } pipe_ctl_t;

  typedef struct packed {
    logic             relay_even;
    logic             relay_odd;
    logic [POS_W-1:0] position;
    phase_e           phase;
    logic             in_sync;
    logic             step_done;
  } res_t;

  // True when the second is a whole multiple of the step boundary.
  function automatic logic sec_on_boundary(logic [5:0] sec);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= 63 / STEP_BOUNDARY; k++) begin
      if (sec == 6'(k * STEP_BOUNDARY)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cpr_target.sv =====
// Two-stage target position unit: window check, then a reciprocal multiply and clamp.
`timescale 1ns / 1ps
`default_nettype none

module cpr_target
  import cpr_pkg::*;
#(
  parameter int unsigned MINUTES_PER_POSITION = cpr_pkg::MINUTES_PER_POSITION
) (
  input  wire               clk_i,
  input  pipe_ctl_t         ctl_i,
  input  cfg_t              cfg_i,
  input  item_t             item_i,
  output item_t             item_o,
  output logic [POS_W-1:0]  target_o
);

  localparam int unsigned ShW    = $clog2(MINUTES_PER_POSITION);
  localparam int unsigned KShift = MIN_W + ShW;
  localparam int unsigned RecipW = KShift + 1;
  localparam int unsigned ProdW  = MIN_W + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << KShift) + 64'(MINUTES_PER_POSITION) - 64'd1) /
            64'(MINUTES_PER_POSITION));

  item_t            item2_q, item3_q;
  logic             in_win_q, in_win_d;
  logic [MIN_W-1:0] diff_q, diff_d;
  logic [MIN_W-1:0] total;
  logic [ProdW-1:0] prod;
  logic [MIN_W-1:0] quot;
  logic [POS_W-1:0] target_q, target_d;

  always_comb begin
    total    = MIN_W'(item_i.hour) * MIN_PER_HOUR + MIN_W'(item_i.minute);
    in_win_d = cfg_i.plate_configured && (total >= cfg_i.start_minute) &&
               (total <= cfg_i.end_minute);
    diff_d   = total - cfg_i.start_minute;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_diff) begin
      item2_q  <= item_i;
      in_win_q <= in_win_d;
      diff_q   <= diff_d;
    end
  end

  always_comb begin
    prod = ProdW'(diff_q) * ProdW'(Recip);
    quot = prod[KShift +: MIN_W];
    if (!in_win_q || (quot > MIN_W'(NIGHT_POS))) begin
      target_d = NIGHT_POS;
    end else begin
      target_d = quot[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_tgt) begin
      item3_q  <= item2_q;
      target_q <= target_d;
    end
  end

  assign item_o   = item3_q;
  assign target_o = target_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cpr_step.sv =====
// Plate stepping state and the registered result of each item.
`timescale 1ns / 1ps
`default_nettype none

module cpr_step
  import cpr_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  logic             ld_i,
  input  item_t            item_i,
  input  logic [POS_W-1:0] target_i,
  output res_t             res_o
);

  logic [POS_W-1:0]  pos_q, pos_d, pos_next;
  phase_e            ph_q, ph_d;
  logic [TICK_W-1:0] tk_q, tk_d, tk_inc;
  logic              done, expired, boundary;
  res_t              res_q, res_d;

  always_comb begin
    pos_d    = pos_q;
    ph_d     = ph_q;
    tk_d     = tk_q;
    done     = 1'b0;
    boundary = sec_on_boundary(item_i.second);
    tk_inc   = (tk_q != TICK_SAT) ? tk_q + TICK_W'(1) : tk_q;
    expired  = tk_inc >= TICK_W'(TICKS_PER_PHASE);
    pos_next = (pos_q == NIGHT_POS) ? '0 : pos_q + POS_W'(1);

    if (item_i.func) begin
      pos_d = (item_i.new_position > NIGHT_POS) ? NIGHT_POS : item_i.new_position;
      ph_d  = PH_STABLE;
      tk_d  = '0;
    end else if (!item_i.time_valid || !item_i.sqw_active || item_i.manual_hold) begin
      ph_d = PH_STABLE;
      tk_d = '0;
    end else if (ph_q != PH_STABLE) begin
      tk_d = tk_inc;
      if (expired && (ph_q == PH_FIRST)) begin
        ph_d = item_i.persist_ok ? PH_SECOND : PH_STABLE;
        tk_d = '0;
      end else if (expired) begin
        pos_d = pos_next;
        done  = 1'b1;
        tk_d  = '0;
        if (boundary && (pos_next != target_i) && item_i.persist_ok) begin
          ph_d = PH_FIRST;
        end else begin
          ph_d = PH_STABLE;
        end
      end
    end else if (boundary && (pos_q != target_i) && item_i.persist_ok) begin
      ph_d = PH_FIRST;
      tk_d = '0;
    end

    res_d.relay_even = !item_i.func && item_i.time_valid && (ph_d == PH_FIRST);
    res_d.relay_odd  = !item_i.func && item_i.time_valid && (ph_d == PH_SECOND);
    res_d.position   = pos_d;
    res_d.phase      = ph_d;
    res_d.in_sync    = item_i.time_valid && (ph_d == PH_STABLE) && (pos_d == target_i);
    res_d.step_done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ph_q  <= PH_STABLE;
      tk_q  <= '0;
    end else if (ld_i) begin
      pos_q <= pos_d;
      ph_q  <= ph_d;
      tk_q  <= tk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/clock_plate_relay_stepper_core.sv =====
// Top level of the clock plate relay stepper: ports, configuration and pipeline control.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item is one RTC second tick or a set-position command and yields
// exactly one result. The block takes one item per clock cycle when the result side
// keeps up; each item passes an input register, two stages that work out the target
// position from the time of day (window check, then a reciprocal multiply and clamp),
// and the output register, where the plate position, phase and tick count are updated
// together with the result so the next item sees them. Configuration writes are taken
// at any time with the ready always high but must only be issued while no item is in
// flight.

module clock_plate_relay_stepper_core
  import cpr_pkg::*;
#(
  parameter int unsigned MINUTES_PER_POSITION = cpr_pkg::MINUTES_PER_POSITION
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // hour[4:0], minute[10:5], second[16:11], time_valid[17], sqw_active[18],
  // manual_hold[19], persist_ok[20], new_position[26:21], zero fill above.
  input  wire  [31:0]  s_axis_tdata,
  // func.
  input  wire          s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // relay_even[0], relay_odd[1], position[7:2], phase[9:8], in_sync[10],
  // step_done[11], zero fill above.
  output logic [15:0]  m_axis_tdata,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [1:0]   cfg_index_i,
  input  wire  [10:0]  cfg_data_i
);

  cfg_t             cfg_q;
  item_t            item1_q, item_in, item3;
  logic             v1_q, v2_q, v3_q, vo_q;
  logic             ld_in;
  pipe_ctl_t        ctl;
  logic [POS_W-1:0] target;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_minute     <= '0;
      cfg_q.end_minute       <= 11'd1439;
      cfg_q.plate_configured <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_MINUTE:     cfg_q.start_minute     <= cfg_data_i;
        CFG_END_MINUTE:       cfg_q.end_minute       <= cfg_data_i;
        CFG_PLATE_CONFIGURED: cfg_q.plate_configured <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.ld_out    = v3_q && (!vo_q || m_axis_tready);
    ctl.ld_tgt    = v2_q && (!v3_q || ctl.ld_out);
    ctl.ld_diff   = v1_q && (!v2_q || ctl.ld_tgt);
    s_axis_tready = !v1_q || ctl.ld_diff;
    ld_in         = s_axis_tvalid && s_axis_tready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= ld_in || (v1_q && !ctl.ld_diff);
      v2_q <= ctl.ld_diff || (v2_q && !ctl.ld_tgt);
      v3_q <= ctl.ld_tgt || (v3_q && !ctl.ld_out);
      vo_q <= ctl.ld_out || (vo_q && !m_axis_tready);
    end
  end

  always_comb begin
    item_in.func         = s_axis_tuser;
    item_in.hour         = s_axis_tdata[4:0];
    item_in.minute       = s_axis_tdata[10:5];
    item_in.second       = s_axis_tdata[16:11];
    item_in.time_valid   = s_axis_tdata[17];
    item_in.sqw_active   = s_axis_tdata[18];
    item_in.manual_hold  = s_axis_tdata[19];
    item_in.persist_ok   = s_axis_tdata[20];
    item_in.new_position = s_axis_tdata[26:21];
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) item1_q <= item_in;
  end

  cpr_target #(
    .MINUTES_PER_POSITION(MINUTES_PER_POSITION)
  ) u_target (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .cfg_i   (cfg_q),
    .item_i  (item1_q),
    .item_o  (item3),
    .target_o(target)
  );

  cpr_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (ctl.ld_out),
    .item_i  (item3),
    .target_i(target),
    .res_o   (res)
  );

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {4'b0000, res.step_done, res.in_sync, res.phase, res.position,
                          res.relay_odd, res.relay_even};

  a_relays_follow_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> ((res.relay_even == 1'b0) || (res.phase == PH_FIRST)) &&
             ((res.relay_odd == 1'b0) || (res.phase == PH_SECOND)))
    else $error("relay drive does not match the step phase");

  a_sync_only_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && res.in_sync) |-> (res.phase == PH_STABLE))
    else $error("in_sync reported while a step is running");

  a_done_not_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && res.step_done) |-> (res.phase != PH_SECOND))
    else $error("finished step left the plate in the second relay phase");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && vo_q))
    else $error("input stalled while the pipeline has a free stage");

endmodule

`default_nettype wire

// ===== sim/tb_clock_plate_relay_stepper_core.sv =====
// Self-checking testbench for the clock plate relay stepper core with directed and random items.
`timescale 1ns / 1ps

module tb_clock_plate_relay_stepper_core;
  import cpr_pkg::*;

  localparam logic       FUNC_TICK    = 1'b0;
  localparam logic       FUNC_SET_POS = 1'b1;
  localparam logic [1:0] CFG_NO_REG   = 2'd3;
  localparam int         MAX_GAP      = 8;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         PHASE_ITEMS  = 26;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  // Schedule registers and plate state as the block should hold them.
  logic [10:0]      win_start = 11'd0;
  logic [10:0]      win_end = 11'd1439;
  logic             sched_on = 1'b0;
  logic [POS_W-1:0] plate_pos = '0;
  phase_e           step_ph = PH_STABLE;
  logic [2:0]       plate_ticks = '0;

  item_t tick_q[$];
  res_t  plate_states_q[$];
  item_t item_now = '0;
  res_t  want;
  bit    send_busy = 1'b0;
  int    send_wait = 0;
  int    recv_wait = 0;
  bit    no_idle = 1'b0;
  int    errors = 0;
  int    quiet_cycles = 0;

  clock_plate_relay_stepper_core u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [POS_W-1:0] target_pos(logic [4:0] hour, logic [5:0] minute);
    int unsigned total;
    int unsigned blocks;
    total = int'(hour) * 60 + int'(minute);
    if (!sched_on || total < win_start || total > win_end) return NIGHT_POS;
    blocks = (total - win_start) / MINUTES_PER_POSITION;
    return (blocks > NIGHT_POS) ? NIGHT_POS : POS_W'(blocks);
  endfunction

  function automatic void try_start(item_t it, logic [POS_W-1:0] tgt);
    if (step_ph == PH_STABLE && it.second % STEP_BOUNDARY == 0 &&
        plate_pos != tgt && it.persist_ok) begin
      step_ph = PH_FIRST;
      plate_ticks = '0;
    end
  endfunction

  function automatic res_t plate_step(item_t it);
    res_t             r;
    logic [POS_W-1:0] tgt;
    logic             done;
    tgt = target_pos(it.hour, it.minute);
    done = 1'b0;
    if (it.func == FUNC_SET_POS) begin
      plate_pos = (it.new_position > NIGHT_POS) ? NIGHT_POS : it.new_position;
      step_ph = PH_STABLE;
      plate_ticks = '0;
    end else if (!it.time_valid || !it.sqw_active || it.manual_hold) begin
      step_ph = PH_STABLE;
      plate_ticks = '0;
    end else if (step_ph != PH_STABLE) begin
      if (plate_ticks != 3'd7) plate_ticks = plate_ticks + 3'd1;
      if (plate_ticks >= TICKS_PER_PHASE) begin
        if (step_ph == PH_FIRST) begin
          step_ph = it.persist_ok ? PH_SECOND : PH_STABLE;
          plate_ticks = '0;
        end else begin
          plate_pos = plate_pos + 1'b1;
          step_ph = PH_STABLE;
          plate_ticks = '0;
          done = 1'b1;
          try_start(it, tgt);
        end
      end
    end else begin
      try_start(it, tgt);
    end
    r.relay_even = it.func == FUNC_TICK && it.time_valid && step_ph == PH_FIRST;
    r.relay_odd = it.func == FUNC_TICK && it.time_valid && step_ph == PH_SECOND;
    r.position = plate_pos;
    r.phase = step_ph;
    r.in_sync = it.time_valid && step_ph == PH_STABLE && plate_pos == tgt;
    r.step_done = done;
    return r;
  endfunction

  function automatic void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  task automatic queue_item(logic func, logic [4:0] hour, logic [5:0] minute,
                            logic [5:0] second, logic valid, logic sqw, logic hold,
                            logic ack, logic [5:0] new_pos);
    item_t it;
    it.func = func;
    it.hour = hour;
    it.minute = minute;
    it.second = second;
    it.time_valid = valid;
    it.sqw_active = sqw;
    it.manual_hold = hold;
    it.persist_ok = ack;
    it.new_position = new_pos;
    tick_q.push_back(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_START_MINUTE:     win_start = val;
      CFG_END_MINUTE:       win_end = val;
      CFG_PLATE_CONFIGURED: sched_on = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (!(tick_q.size() == 0 && !send_busy && plate_states_q.size() == 0))
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        plate_states_q.push_back(plate_step(item_now));
        send_busy = 1'b0;
        send_wait = draw_gap();
      end
      if (!send_busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (tick_q.size() > 0) begin
          item_now = tick_q.pop_front();
          send_busy = 1'b1;
        end
      end
      s_axis_tvalid <= send_busy;
      s_axis_tdata <= {5'd0, item_now.new_position, item_now.persist_ok,
                       item_now.manual_hold, item_now.sqw_active, item_now.time_valid,
                       item_now.second, item_now.minute, item_now.hour};
      s_axis_tuser <= item_now.func;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (plate_states_q.size() == 0) begin
          $display("%0t: no item expected, got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = plate_states_q.pop_front();
          cmp_field("relay_even", want.relay_even, m_axis_tdata[0]);
          cmp_field("relay_odd", want.relay_odd, m_axis_tdata[1]);
          cmp_field("position", want.position, m_axis_tdata[7:2]);
          cmp_field("phase", want.phase, m_axis_tdata[9:8]);
          cmp_field("in_sync", want.in_sync, m_axis_tdata[10]);
          cmp_field("step_done", want.step_done, m_axis_tdata[11]);
        end
        recv_wait = draw_gap();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [10:0] s_val;
    logic [10:0] e_val;
    logic [10:0] c_val;
    logic [31:0] rnd;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [5:0]  sec;
    item_t       noise;
    int          e_int;
    int          n;
    int          len;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unconfigured plate: the target is always the night position.
    queue_item(FUNC_SET_POS, 5'd31, 6'd63, 6'd63, 1'b1, 1'b1, 1'b1, 1'b1, 6'd63);
    queue_item(FUNC_SET_POS, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
    queue_item(FUNC_TICK, 5'd0, 6'd0, 6'd0, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0);
    for (int s = 0; s <= 12; s++)
      queue_item(FUNC_TICK, 5'd0, 6'd0, 6'(s), 1'b1, 1'b1, 1'b0, 1'b1, 6'd0);
    queue_item(FUNC_TICK, 5'd0, 6'd0, 6'd13, 1'b0, 1'b1, 1'b0, 1'b1, 6'd0);
    queue_item(FUNC_TICK, 5'd0, 6'd0, 6'd18, 1'b1, 1'b1, 1'b0, 1'b1, 6'd0);
    queue_item(FUNC_TICK, 5'd0, 6'd0, 6'd19, 1'b1, 1'b1, 1'b1, 1'b1, 6'd0);
    for (int s = 24; s <= 30; s++)
      queue_item(FUNC_TICK, 5'd0, 6'd0, 6'(s), 1'b1, 1'b1, 1'b0, s != 30, 6'd0);
    queue_item(FUNC_TICK, 5'd0, 6'd0, 6'd31, 1'b1, 1'b0, 1'b0, 1'b1, 6'd0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin s_val = 11'd0;    e_val = 11'd1439; c_val = 11'd1; end
        1: begin s_val = 11'd480;  e_val = 11'd1200; c_val = 11'd1; end
        2: begin s_val = 11'd2047; e_val = 11'd2047; c_val = 11'd1; end
        3: begin s_val = 11'd1439; e_val = 11'd0;    c_val = 11'd1; end
        4: begin s_val = 11'd0;    e_val = 11'd2047; c_val = 11'h7FE; end
        default: begin
          s_val = 11'($urandom_range(0, 1439));
          e_int = int'(s_val) + $urandom_range(0, 400);
          e_val = (e_int > 2047) ? 11'd2047 : 11'(e_int);
          rnd = $urandom;
          c_val = {rnd[10:1], ($urandom_range(0, 5) != 0)};
        end
      endcase
      write_reg(CFG_START_MINUTE, s_val);
      write_reg(CFG_END_MINUTE, e_val);
      write_reg(CFG_PLATE_CONFIGURED, c_val);
      if (ph == 4 || $urandom_range(0, 2) == 0) begin
        rnd = $urandom;
        write_reg(CFG_NO_REG, (ph == 4) ? 11'h7FF : rnd[10:0]);
      end

      no_idle = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          rnd = $urandom;
          noise = rnd[27:0];
          tick_q.push_back(noise);
          n++;
        end else begin
          // A run of consecutive seconds, mostly clean so that steps run to completion.
          h = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                                            5'($urandom_range(0, 23));
          m = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) :
                                            6'($urandom_range(0, 59));
          sec = 6'(6 * $urandom_range(0, 9));
          len = $urandom_range(14, 40);
          if ($urandom_range(0, 3) == 0) begin
            queue_item(FUNC_SET_POS, h, m, sec, 1'b1, 1'b1, 1'b0, 1'b1,
                       target_pos(h, m) - 6'($urandom_range(0, 1)));
            n++;
          end
          repeat (len) begin
            rnd = $urandom;
            queue_item(($urandom_range(0, 60) == 0), h, m, sec,
                       ($urandom_range(0, 40) != 0), ($urandom_range(0, 40) != 0),
                       ($urandom_range(0, 40) == 0), ($urandom_range(0, 25) != 0),
                       rnd[5:0]);
            n++;
            sec = sec + 6'd1;
            if (sec >= 6'd60) begin
              sec = 6'd0;
              m = m + 6'd1;
              if (m >= 6'd60) begin
                m = 6'd0;
                h = (h == 5'd23) ? 5'd0 : h + 5'd1;
              end
            end
          end
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== clock_plate_relay_stepper_core.f =====
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_target.sv
hw/rtl/cpr_step.sv
hw/rtl/clock_plate_relay_stepper_core.sv
sim/tb_clock_plate_relay_stepper_core.sv
